>>> rtl/pendulum_pid_duty_controller_core_macros.svh
// Assertion macros shared by the pendulum PID duty controller RTL.
// Each use expands to one labelled concurrent assertion on clk, disabled in reset.
`ifndef PENDULUM_PID_DUTY_CONTROLLER_CORE_MACROS_SVH
`define PENDULUM_PID_DUTY_CONTROLLER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PDC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pdc same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PDC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pdc next-cycle check failed");

`endif

>>> rtl/pdc_pkg.sv
// Package for the pendulum PID duty controller: types, register indexes and constants.
// No dependencies; used by pdc_cfg_regs and the top level.
`default_nettype none

package pdc_pkg;

	// Field widths fixed by the interface.
	localparam int unsigned SAMPLE_W = 10;
	localparam int unsigned GAIN_W   = 24;
	localparam int unsigned LIMIT_W  = 23;
	localparam int unsigned THRESH_W = 16;
	localparam int unsigned DUTY_W   = 17;
	localparam int unsigned IDX_W    = 3;

	// Configuration register indexes.
	typedef enum logic [IDX_W-1:0] {
		REG_ZERO_LEVEL     = 3'd0,
		REG_KP_GAIN        = 3'd1,
		REG_KI_GAIN        = 3'd2,
		REG_KD_GAIN        = 3'd3,
		REG_INTEGRAL_LIMIT = 3'd4,
		REG_LED_THRESHOLD  = 3'd5
	} reg_idx_t;

	// LED zone codes.
	typedef enum logic [1:0] {
		ZONE_POS_STRONG = 2'd0,
		ZONE_POS_WEAK   = 2'd1,
		ZONE_NEG_WEAK   = 2'd2,
		ZONE_NEG_STRONG = 2'd3
	} zone_t;

	// Register values after reset.
	localparam logic [SAMPLE_W-1:0]        ZERO_LEVEL_RST = 10'd754;
	localparam logic signed [GAIN_W-1:0]   KP_GAIN_RST    = 24'sd634970;
	localparam logic signed [GAIN_W-1:0]   KI_GAIN_RST    = 24'sd63497;
	localparam logic signed [GAIN_W-1:0]   KD_GAIN_RST    = 24'sd63497;
	localparam logic [LIMIT_W-1:0]         LIMIT_RST      = 23'd1834862;
	localparam logic [THRESH_W-1:0]        THRESH_RST     = 16'd26214;

	// Duty saturation bounds (Q15, full scale).
	localparam logic signed [DUTY_W-1:0] DUTY_MAX = 17'sd32768;
	localparam logic signed [DUTY_W-1:0] DUTY_MIN = -17'sd32768;

	// Configuration as seen by the datapath.
	typedef struct packed {
		logic [SAMPLE_W-1:0]      zero_level;
		logic signed [GAIN_W-1:0] kp_gain;
		logic signed [GAIN_W-1:0] ki_gain;
		logic signed [GAIN_W-1:0] kd_gain;
		logic [LIMIT_W-1:0]       integral_limit;
		logic [THRESH_W-1:0]      led_threshold;
	} cfg_t;

endpackage

`default_nettype wire

>>> rtl/pdc_cfg_regs.sv
// Configuration register file of the pendulum PID duty controller.
// Depends on pdc_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module pdc_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	input  wire logic [pdc_pkg::IDX_W-1:0]       cfg_index,
	input  wire logic [pdc_pkg::GAIN_W-1:0]      cfg_data,
	output pdc_pkg::cfg_t                        cfg
);

	pdc_pkg::cfg_t cfg_q;

	// Writes are always accepted; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_level     <= pdc_pkg::ZERO_LEVEL_RST;
			cfg_q.kp_gain        <= pdc_pkg::KP_GAIN_RST;
			cfg_q.ki_gain        <= pdc_pkg::KI_GAIN_RST;
			cfg_q.kd_gain        <= pdc_pkg::KD_GAIN_RST;
			cfg_q.integral_limit <= pdc_pkg::LIMIT_RST;
			cfg_q.led_threshold  <= pdc_pkg::THRESH_RST;
		end else if (cfg_valid) begin
			unique case (pdc_pkg::reg_idx_t'(cfg_index))
				pdc_pkg::REG_ZERO_LEVEL: begin
					cfg_q.zero_level <= cfg_data[pdc_pkg::SAMPLE_W-1:0];
				end
				pdc_pkg::REG_KP_GAIN: begin
					cfg_q.kp_gain <= $signed(cfg_data);
				end
				pdc_pkg::REG_KI_GAIN: begin
					cfg_q.ki_gain <= $signed(cfg_data);
				end
				pdc_pkg::REG_KD_GAIN: begin
					cfg_q.kd_gain <= $signed(cfg_data);
				end
				pdc_pkg::REG_INTEGRAL_LIMIT: begin
					cfg_q.integral_limit <= cfg_data[pdc_pkg::LIMIT_W-1:0];
				end
				pdc_pkg::REG_LED_THRESHOLD: begin
					cfg_q.led_threshold <= cfg_data[pdc_pkg::THRESH_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> rtl/pendulum_pid_duty_controller_core.sv
// Top level of the pendulum PID duty controller: four-stage datapath and handshakes.
// Depends on pdc_pkg, pdc_cfg_regs and pendulum_pid_duty_controller_core_macros.svh.
//
//   Channel   Signals                          Direction   Payload
//   sample    adc_valid / adc_ready            in          adc_sample
//   result    res_valid / res_ready            out         duty, led_zone
//   config    cfg_valid / cfg_ready            in          cfg_index, cfg_data
//
// One item is accepted per cycle unless stalled; it passes sample_s1, the s2 and s3 registers and duty_s4 in order.
// The integral and previous error are updated in stage two, in the same cycle that stage loads.
// Each stage holds only while it is full and the stage after it is blocked.
// Reset clears the configuration to its defaults and the state and valids to zero.
// Configuration writes are taken every cycle (cfg_ready is tied high).
`default_nettype none
`include "pendulum_pid_duty_controller_core_macros.svh"

module pendulum_pid_duty_controller_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                adc_valid,
	output logic                                     adc_ready,
	input  wire logic [pdc_pkg::SAMPLE_W-1:0]        adc_sample,
	output logic                                     res_valid,
	input  wire logic                                res_ready,
	output logic signed [pdc_pkg::DUTY_W-1:0]        duty,
	output logic [1:0]                               led_zone,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [pdc_pkg::IDX_W-1:0]           cfg_index,
	input  wire logic [pdc_pkg::GAIN_W-1:0]          cfg_data
);

	pdc_pkg::cfg_t cfg;

	// Pipeline valids and per-stage ready.
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	// Stage payloads.
	logic [pdc_pkg::SAMPLE_W-1:0] sample_s1;
	logic signed [10:0]           err_s2;
	logic signed [11:0]           derr_s2;
	logic signed [23:0]           integ_s2;
	logic signed [34:0]           pkp_s3;
	logic signed [47:0]           pki_s3;
	logic signed [35:0]           pkd_s3;
	logic signed [pdc_pkg::DUTY_W-1:0] duty_s4;
	pdc_pkg::zone_t               zone_s4;

	// Controller state.
	logic signed [10:0] prev_err_q;
	logic signed [23:0] integ_q;

	// Combinational values.
	logic signed [10:0] err_c;
	logic signed [11:0] derr_c;
	logic signed [24:0] integ_sum_c;
	logic signed [24:0] lim_pos_c;
	logic signed [24:0] lim_neg_c;
	logic signed [23:0] integ_c;
	logic signed [49:0] sum_c;
	logic signed [41:0] shifted_c;
	logic signed [pdc_pkg::DUTY_W-1:0] duty_c;
	logic signed [17:0] thr_pos_c;
	logic signed [17:0] thr_neg_c;
	logic signed [17:0] duty_ext_c;
	pdc_pkg::zone_t     zone_c;
	logic               upd_s2;

	pdc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign cfg_ready = 1'b1;

	// A stage may load when it is empty or its contents move on.
	assign rdy_s4    = !v_s4 || res_ready;
	assign rdy_s3    = !v_s3 || rdy_s4;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign adc_ready = rdy_s1;
	assign upd_s2    = v_s1 && rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= adc_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// Stage 1: input register.
	always_ff @(posedge clk) begin
		if (rdy_s1 && adc_valid) begin
			sample_s1 <= adc_sample;
		end
	end

	// Stage 2: error, derivative and clamped integral.
	assign err_c       = $signed({1'b0, cfg.zero_level}) - $signed({1'b0, sample_s1});
	assign derr_c      = 12'(err_c) - 12'(prev_err_q);
	assign integ_sum_c = 25'(integ_q) + 25'(err_c);
	assign lim_pos_c   = $signed({2'b00, cfg.integral_limit});
	assign lim_neg_c   = -lim_pos_c;

	always_comb begin
		if (integ_sum_c > lim_pos_c) begin
			integ_c = lim_pos_c[23:0];
		end else if (integ_sum_c < lim_neg_c) begin
			integ_c = lim_neg_c[23:0];
		end else begin
			integ_c = integ_sum_c[23:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
			integ_q    <= '0;
		end else if (upd_s2) begin
			prev_err_q <= err_c;
			integ_q    <= integ_c;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_s2) begin
			err_s2   <= err_c;
			derr_s2  <= derr_c;
			integ_s2 <= integ_c;
		end
	end

	// Stage 3: the three gain products.
	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			pkp_s3 <= 35'(cfg.kp_gain) * 35'(err_s2);
			pki_s3 <= 48'(cfg.ki_gain) * 48'(integ_s2);
			pkd_s3 <= 36'(cfg.kd_gain) * 36'(derr_s2);
		end
	end

	// Stage 4: sum, floor shift by eight, saturate and classify.
	assign sum_c     = 50'(pkp_s3) + 50'(pki_s3) + 50'(pkd_s3);
	assign shifted_c = sum_c[49:8];

	always_comb begin
		if (shifted_c > 42'(pdc_pkg::DUTY_MAX)) begin
			duty_c = pdc_pkg::DUTY_MAX;
		end else if (shifted_c < 42'(pdc_pkg::DUTY_MIN)) begin
			duty_c = pdc_pkg::DUTY_MIN;
		end else begin
			duty_c = shifted_c[pdc_pkg::DUTY_W-1:0];
		end
	end

	assign thr_pos_c  = $signed({2'b00, cfg.led_threshold});
	assign thr_neg_c  = -thr_pos_c;
	assign duty_ext_c = 18'(duty_c);

	always_comb begin
		if (duty_ext_c > thr_pos_c) begin
			zone_c = pdc_pkg::ZONE_POS_STRONG;
		end else if (!duty_ext_c[17]) begin
			zone_c = pdc_pkg::ZONE_POS_WEAK;
		end else if (duty_ext_c >= thr_neg_c) begin
			zone_c = pdc_pkg::ZONE_NEG_WEAK;
		end else begin
			zone_c = pdc_pkg::ZONE_NEG_STRONG;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			duty_s4 <= duty_c;
			zone_s4 <= zone_c;
		end
	end

	assign res_valid = v_s4;
	assign duty      = duty_s4;
	assign led_zone  = zone_s4;

	// Checks on the datapath and state.
	`PDC_ASSERT_NEXT(a_integ_in_limit, upd_s2, (integ_q <= $past(lim_pos_c)) && (integ_q >= $past(lim_neg_c)))
	`PDC_ASSERT_NEXT(a_prev_err_tracks, upd_s2, prev_err_q == $past(err_c))
	`PDC_ASSERT_NOW(a_duty_range, res_valid, (duty_s4 <= pdc_pkg::DUTY_MAX) && (duty_s4 >= pdc_pkg::DUTY_MIN))
	`PDC_ASSERT_NOW(a_zone_sign, res_valid, (zone_s4 == pdc_pkg::ZONE_POS_STRONG || zone_s4 == pdc_pkg::ZONE_POS_WEAK) == !duty_s4[pdc_pkg::DUTY_W-1])

endmodule

`default_nettype wire

>>> tb/sv/pdc_duty_checker.sv
`timescale 1ns / 1ps
// Checker for the pendulum PID duty controller. It follows the sample, result and register
// channels, predicts the duty and LED zone of every sample item and compares them in order.
// Depends on pdc_pkg for field widths, register indexes, reset values and zone codes.

module pdc_duty_checker
	import pdc_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adc_valid,
	input  logic                       adc_ready,
	input  logic [SAMPLE_W-1:0]        adc_sample,
	input  logic                       res_valid,
	input  logic                       res_ready,
	input  logic signed [DUTY_W-1:0]   duty,
	input  logic [1:0]                 led_zone,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [IDX_W-1:0]           cfg_index,
	input  logic [GAIN_W-1:0]          cfg_data,
	output int                         fail_count,
	output int                         outstanding,
	output int                         checked
);

	typedef struct packed {
		logic signed [DUTY_W-1:0] duty;
		zone_t                    zone;
	} duty_zone_t;

	// Shadow copy of the register file.
	logic [SAMPLE_W-1:0]      zero_lvl;
	logic signed [GAIN_W-1:0] kp;
	logic signed [GAIN_W-1:0] ki;
	logic signed [GAIN_W-1:0] kd;
	logic [LIMIT_W-1:0]       int_limit;
	logic [THRESH_W-1:0]      led_thr;

	// Controller state: error of the last sample and the clamped error sum.
	logic signed [SAMPLE_W:0] last_error;
	logic signed [GAIN_W-1:0] error_sum;

	duty_zone_t expected_duty_q[$];
	duty_zone_t want;
	int         mismatches;
	int         compared;

	// Advances the controller state by one sample and returns the duty and zone it gives.
	function automatic duty_zone_t advance_pid(input logic [SAMPLE_W-1:0] sample);
		longint     err;
		longint     err_diff;
		longint     err_acc;
		longint     lim;
		longint     acc;
		longint     q15;
		longint     thr;
		duty_zone_t res;
		err      = longint'(zero_lvl) - longint'(sample);
		err_diff = err - longint'(last_error);
		lim      = longint'(int_limit);
		thr      = longint'(led_thr);

		// The clamp is applied after the new error has been added.
		err_acc = longint'(error_sum) + err;
		if (err_acc > lim)
			err_acc = lim;
		if (err_acc < -lim)
			err_acc = -lim;
		last_error = err[SAMPLE_W:0];
		error_sum  = err_acc[GAIN_W-1:0];

		// An arithmetic shift of the exact sum floors towards minus infinity.
		acc = longint'(kp) * err + longint'(ki) * err_acc + longint'(kd) * err_diff;
		q15 = acc >>> 8;
		if (q15 > longint'(DUTY_MAX))
			q15 = longint'(DUTY_MAX);
		if (q15 < longint'(DUTY_MIN))
			q15 = longint'(DUTY_MIN);
		res.duty = q15[DUTY_W-1:0];

		if (q15 > thr)
			res.zone = ZONE_POS_STRONG;
		else if (q15 >= 0)
			res.zone = ZONE_POS_WEAK;
		else if (q15 >= -thr)
			res.zone = ZONE_NEG_WEAK;
		else
			res.zone = ZONE_NEG_STRONG;
		return res;
	endfunction

	// Register writes, prediction on each accepted sample, comparison on each accepted result.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_lvl   = ZERO_LEVEL_RST;
			kp         = KP_GAIN_RST;
			ki         = KI_GAIN_RST;
			kd         = KD_GAIN_RST;
			int_limit  = LIMIT_RST;
			led_thr    = THRESH_RST;
			last_error = '0;
			error_sum  = '0;
			expected_duty_q.delete();
			mismatches = 0;
			compared   = 0;
			fail_count  <= 0;
			outstanding <= 0;
			checked     <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ZERO_LEVEL:     zero_lvl  = cfg_data[SAMPLE_W-1:0];
					REG_KP_GAIN:        kp        = cfg_data;
					REG_KI_GAIN:        ki        = cfg_data;
					REG_KD_GAIN:        kd        = cfg_data;
					REG_INTEGRAL_LIMIT: int_limit = cfg_data[LIMIT_W-1:0];
					REG_LED_THRESHOLD:  led_thr   = cfg_data[THRESH_W-1:0];
					default: ;
				endcase
			end

			if (adc_valid && adc_ready)
				expected_duty_q.push_back(advance_pid(adc_sample));

			if (res_valid && res_ready) begin
				if (expected_duty_q.size() == 0) begin
					$error("unexpected result item: duty %0d, led_zone %0d", duty, led_zone);
					mismatches++;
				end else begin
					want = expected_duty_q.pop_front();
					compared++;
					if (duty !== want.duty) begin
						$error("duty: expected %0d, actual %0d", want.duty, duty);
						mismatches++;
					end
					if (led_zone !== want.zone) begin
						$error("led_zone: expected %0d, actual %0d", want.zone, led_zone);
						mismatches++;
					end
				end
			end

			fail_count  <= mismatches;
			outstanding <= expected_duty_q.size();
			checked     <= compared;
		end
	end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Top of the pendulum PID duty controller testbench: clock, reset, sample and register
// stimulus, result back-pressure and the verdict. Depends on pdc_pkg and pdc_duty_checker.

module tb;
	import pdc_pkg::*;

	localparam int PIPE_LATENCY  = 4;
	localparam int SETTLE_CYCLES = 2 * PIPE_LATENCY;
	localparam int HOLD_CYCLES   = 120;
	localparam int STALL_LIMIT   = 1000;
	localparam int RANDOM_ITEMS  = 850;

	// Indexes that decode to no register.
	localparam logic [IDX_W-1:0] IDX_SPARE_LO = 3'd6;
	localparam logic [IDX_W-1:0] IDX_SPARE_HI = 3'd7;

	typedef enum int {SINK_ALWAYS, SINK_COIN, SINK_MOSTLY} sink_mode_t;

	logic                     clk;
	logic                     arst_n;
	logic                     adc_valid;
	logic                     adc_ready;
	logic [SAMPLE_W-1:0]      adc_sample;
	logic                     res_valid;
	logic                     res_ready;
	logic signed [DUTY_W-1:0] duty;
	logic [1:0]               led_zone;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [IDX_W-1:0]         cfg_index;
	logic [GAIN_W-1:0]        cfg_data;

	int fail_count;
	int outstanding;
	int checked;

	int                  samples_sent;
	int                  reg_writes;
	int                  register_sets;
	logic [SAMPLE_W-1:0] cur_zero;
	bit                  hold_off_req;

	pendulum_pid_duty_controller_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.adc_valid  (adc_valid),
		.adc_ready  (adc_ready),
		.adc_sample (adc_sample),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.duty       (duty),
		.led_zone   (led_zone),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	pdc_duty_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.adc_valid   (adc_valid),
		.adc_ready   (adc_ready),
		.adc_sample  (adc_sample),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.duty        (duty),
		.led_zone    (led_zone),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.checked     (checked)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offers one sample item and returns at the edge where it is accepted; valid stays high.
	task automatic send_sample(input logic [SAMPLE_W-1:0] value);
		adc_valid  <= 1'b1;
		adc_sample <= value;
		do @(posedge clk); while (!adc_ready);
		samples_sent++;
	endtask

	// Writes one register; valid stays high so that writes can follow back to back.
	task automatic write_reg(input logic [IDX_W-1:0] index, input logic [GAIN_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		reg_writes++;
	endtask

	// Waits until every predicted result has arrived and the pipeline has had time to drain.
	task automatic settle();
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Loads a complete register set while the block is idle; when spare is set, a write to an unused
	// index comes last so that a decoding fault would corrupt a live register.
	task automatic program_all(input logic [GAIN_W-1:0] zl, input logic [GAIN_W-1:0] p,
			input logic [GAIN_W-1:0] i, input logic [GAIN_W-1:0] d,
			input logic [GAIN_W-1:0] lim, input logic [GAIN_W-1:0] thr, input bit spare);
		settle();
		write_reg(REG_ZERO_LEVEL, zl);
		write_reg(REG_KP_GAIN, p);
		write_reg(REG_KI_GAIN, i);
		write_reg(REG_KD_GAIN, d);
		write_reg(REG_INTEGRAL_LIMIT, lim);
		write_reg(REG_LED_THRESHOLD, thr);
		if (spare)
			write_reg($urandom_range(0, 1) ? IDX_SPARE_HI : IDX_SPARE_LO, GAIN_W'($urandom));
		cfg_valid <= 1'b0;
		cur_zero = zl[SAMPLE_W-1:0];
		register_sets++;
	endtask

	// Mostly readings around the balance point, with some anywhere on the scale.
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int centre;
		if ($urandom_range(0, 9) < 3)
			return SAMPLE_W'($urandom);
		centre = int'(cur_zero) + int'($urandom_range(0, 64)) - 32;
		if (centre < 0)
			centre = 0;
		if (centre > 1023)
			centre = 1023;
		return centre[SAMPLE_W-1:0];
	endfunction

	// Gains from the extremes through every magnitude down to zero, either sign.
	function automatic logic [GAIN_W-1:0] rand_gain();
		logic [31:0] raw;
		raw = $urandom;
		case ($urandom_range(0, 9))
			0: return 24'h800000;
			1: return 24'h7FFFFF;
			2: return 24'h000000;
			3: return raw[GAIN_W-1:0];
			default: begin
				raw = raw >> $urandom_range(8, 31);
				if ($urandom_range(0, 1))
					raw = -raw;
				return raw[GAIN_W-1:0];
			end
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] rand_limit();
		case ($urandom_range(0, 7))
			0: return 24'h000000;
			1: return 24'hFFFFFF;
			2: return GAIN_W'($urandom);
			default: return GAIN_W'($urandom_range(0, 4000));
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] rand_thresh();
		case ($urandom_range(0, 7))
			0: return 24'h000000;
			1: return 24'h008000;
			2: return GAIN_W'($urandom);
			default: return GAIN_W'($urandom_range(0, 32768));
		endcase
	endfunction

	// Sends a run of sample items in bursts with random gaps, or as one unbroken burst.
	task automatic send_run(input int count, input bit gapless);
		int left;
		int burst;
		int gap;
		left = count;
		while (left > 0) begin
			burst = gapless ? left : $urandom_range(1, 20);
			if (burst > left)
				burst = left;
			repeat (burst) send_sample(pick_sample());
			left -= burst;
			gap = 0;
			if (left > 0 && !gapless && $urandom_range(0, 2) != 0)
				gap = $urandom_range(1, 6);
			if (gap > 0) begin
				adc_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		adc_valid <= 1'b0;
	endtask

	// Result back-pressure: changing stall patterns, plus one long hold-off on request.
	initial begin : result_sink
		sink_mode_t mode;
		int         mode_left;
		int         hold_left;
		res_ready = 1'b0;
		mode      = SINK_ALWAYS;
		mode_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = sink_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(10, 80);
				end
				mode_left--;
				case (mode)
					SINK_ALWAYS: res_ready <= 1'b1;
					SINK_COIN:   res_ready <= 1'($urandom_range(0, 1));
					default:     res_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// Ends the run if no channel has moved an item for too long.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (adc_valid && adc_ready) || (res_valid && res_ready)
					|| (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("No item moved for %0d cycles; %0d results still outstanding.",
			STALL_LIMIT, outstanding);
		$display("[pendulum_pid_duty_controller_core] ERROR");
		$finish;
	end

	// Stimulus and verdict.
	initial begin : stimulus
		int left;
		int n;
		int phase;
		arst_n        = 1'b0;
		adc_valid     = 1'b0;
		adc_sample    = '0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_ZERO_LEVEL;
		cfg_data      = '0;
		hold_off_req  = 1'b0;
		samples_sent  = 0;
		reg_writes    = 0;
		register_sets = 0;
		cur_zero      = ZERO_LEVEL_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset gains: both saturation limits, zero error, and a settled integral.
		send_sample(10'd0);
		send_sample(10'd1023);
		send_sample(10'd754);
		send_sample(10'd754);
		send_sample(10'd0);
		send_sample(10'd0);
		send_sample(10'd1023);
		adc_valid <= 1'b0;

		// Duty equals the error with a zero threshold: zero duty must land in the weak
		// positive zone, and any negative duty in the strong negative one.
		program_all(24'h000200, 24'h000100, 24'h000000, 24'h000000, 24'h000000, 24'h000000,
			1'b1);
		send_sample(10'd512);
		send_sample(10'd513);
		send_sample(10'd511);
		send_sample(10'd0);
		send_sample(10'd1023);
		adc_valid <= 1'b0;

		// Unit gain: the shift must floor, never round to nearest.
		program_all(24'h000200, 24'h000001, 24'h000000, 24'h000000, 24'h000000, 24'h000000,
			1'b0);
		send_sample(10'd513);
		send_sample(10'd257);
		send_sample(10'd768);
		send_sample(10'd769);
		adc_valid <= 1'b0;

		// Extreme gains and limits with all data bits set; a threshold above full scale
		// leaves only the two weak zones.
		program_all(24'hFFFFFF, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'hFFFFFF, 24'hFFFFFF,
			1'b1);
		send_sample(10'd0);
		send_sample(10'd0);
		send_sample(10'd1023);
		send_sample(10'd0);
		adc_valid <= 1'b0;

		// Integral only, with a tight clamp that is reached from both sides.
		program_all(24'h000200, 24'h000000, 24'h000100, 24'h000000, 24'h000005, 24'h008000,
			1'b0);
		send_sample(10'd510);
		send_sample(10'd510);
		send_sample(10'd510);
		send_sample(10'd1023);
		adc_valid <= 1'b0;

		// Random register sets, each followed by a run of samples; one run meets a long
		// hold-off at the result side so that the pipeline fills and stalls its input.
		left  = RANDOM_ITEMS;
		phase = 0;
		while (left > 0) begin
			program_all(GAIN_W'($urandom), rand_gain(), rand_gain(), rand_gain(), rand_limit(),
				rand_thresh(), $urandom_range(0, 3) == 0);
			n = $urandom_range(30, 110);
			if (n > left)
				n = left;
			if (phase == 2) begin
				hold_off_req = 1'b1;
				send_run(n, 1'b1);
			end else begin
				send_run(n, 1'b0);
			end
			left -= n;
			phase++;
		end

		settle();
		$display("Run covered %0d samples under %0d register sets (%0d register writes).",
			samples_sent, register_sets, reg_writes);
		$display("%0d results compared with the predicted duty and LED zone; %0d mismatches.",
			checked, fail_count);
		if (fail_count == 0 && outstanding == 0)
			$display("[pendulum_pid_duty_controller_core] OK");
		else
			$display("[pendulum_pid_duty_controller_core] ERROR");
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/pdc_pkg.sv
rtl/pdc_cfg_regs.sv
rtl/pendulum_pid_duty_controller_core.sv
tb/sv/pdc_duty_checker.sv
tb/sv/tb.sv
